### rtl/core/itoa_pkg.sv
// itoa_pkg: shared types and defaults for the integer-to-ASCII formatter.
// Holds the input/output transaction structs and the controller/datapath
// command and status structs. No dependencies.
package itoa_pkg;

  // Default sizing handed to the top level
  localparam int unsigned CORE_LEN_DEF   = 32;
  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Radix select codes (anything else formats as decimal)
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;

  // One number plus its conversion spec
  typedef struct packed {
    logic [31:0] magnitude;
    logic        negative;
    logic [1:0]  radix_sel;
    logic        upper_case;
    logic        signed_conv;
    logic        precision_given;
    logic [5:0]  min_digits;
    logic [6:0]  field_width;
    logic        zero_pad;
    logic        left_align;
    logic        plus_sign;
    logic        space_sign;
  } itoa_in_t;

  // One output character
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } itoa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic push_digit;
    logic push_zero;
    logic push_sign;
    logic prep;
    logic emit;
  } itoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_digits;
    logic is_dec;
    logic dabble_last;
    logic more_digits;
    logic need_zero;
    logic rem_zero;
    logic last_one;
    logic out_free;
  } itoa_sts_t;

endpackage

### rtl/core/itoa_ctrl.sv
// itoa_ctrl: sequencing state machine of the integer-to-ASCII formatter.
// Drives itoa_cmd_t to the datapath and reads itoa_sts_t back.
// Depends on itoa_pkg.
module itoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itoa_pkg::itoa_sts_t sts_i,
  output itoa_pkg::itoa_cmd_t cmd_o
);
  import itoa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DABBLE = 3'd2;
  localparam logic [2:0] ST_DIGIT  = 3'd3;
  localparam logic [2:0] ST_PAD    = 3'd4;
  localparam logic [2:0] ST_SIGN   = 3'd5;
  localparam logic [2:0] ST_PREP   = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  // Input side is open only between numbers
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.skip_digits) begin
          state_d = ST_PAD;
        end else if (sts_i.is_dec) begin
          state_d = ST_DABBLE;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DABBLE: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.dabble_last) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.push_digit = 1'b1;
        if (!sts_i.more_digits) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (sts_i.need_zero) begin
          cmd_o.push_zero = 1'b1;
        end else begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd_o.push_sign = 1'b1;
        state_d         = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.rem_zero) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/itoa_dp.sv
// itoa_dp: datapath of the integer-to-ASCII formatter.
// Binary-to-BCD shifter, digit extractor, character stack, pad counters and
// the output register. Depends on itoa_pkg.
module itoa_dp #(
  parameter int unsigned CORE_LEN   = itoa_pkg::CORE_LEN_DEF,
  parameter int unsigned MAX_WIDTH  = itoa_pkg::MAX_WIDTH_DEF,
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itoa_pkg::itoa_in_t  in_data_i,
  input  itoa_pkg::itoa_cmd_t cmd_i,
  output itoa_pkg::itoa_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itoa_pkg::itoa_out_t out_data_o
);
  import itoa_pkg::*;

  localparam int unsigned LEN_W  = $clog2(CORE_LEN + 1);
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned NDEC   = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned WORK_W = 4 * NDEC;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned FW     = (WID_W > 7) ? WID_W : 7;
  localparam int unsigned PW     = (LEN_W > 6) ? LEN_W : 6;
  localparam int unsigned TW     = (WID_W > LEN_W) ? WID_W : LEN_W;
  localparam int unsigned SW     = TW + 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Per-number settings
  logic              dec_q, oct_q, upper_q, left_q, lead_sp_q, sign_q, skip_q;
  logic [7:0]        sign_ch_q;
  logic [WID_W-1:0]  width_q;
  logic [LEN_W-1:0]  tgt_q;
  // Conversion registers
  logic [VALUE_BITS-1:0] bin_q;
  logic [WORK_W-1:0]     work_q;
  logic [CNT_W-1:0]      cnt_q;
  // Character stack, top at index 0
  logic [7:0]        core_q [CORE_LEN];
  logic [LEN_W-1:0]  len_q;
  logic [WID_W-1:0]  lead_q, trail_q;
  // Output register
  logic              out_valid_q;
  itoa_out_t         out_q;

  // ---------------- decode of the incoming spec ----------------
  logic [VALUE_BITS-1:0] val;
  logic [PW-1:0]         prec_raw;
  logic [LEN_W-1:0]      prec;
  logic [FW-1:0]         wid_raw;
  logic [WID_W-1:0]      wid, eff_w, pad_w;
  logic [TW-1:0]         tgt_raw;
  logic [LEN_W-1:0]      tgt;
  logic                  plus_eff, space_eff, has_sign, zpad_eff;
  logic [7:0]            sign_ch;

  always_comb begin
    val       = VALUE_BITS'(in_data_i.magnitude);
    prec_raw  = PW'(in_data_i.min_digits);
    prec      = (prec_raw > PW'(CORE_LEN)) ? LEN_W'(CORE_LEN) : LEN_W'(prec_raw);
    wid_raw   = FW'(in_data_i.field_width);
    wid       = (wid_raw > FW'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(wid_raw);
    plus_eff  = in_data_i.plus_sign & in_data_i.signed_conv;
    space_eff = in_data_i.space_sign & in_data_i.signed_conv;
    has_sign  = in_data_i.negative | plus_eff | space_eff;
    sign_ch   = in_data_i.negative ? CH_MINUS : (plus_eff ? CH_PLUS : CH_SPACE);
    zpad_eff  = in_data_i.zero_pad & ~in_data_i.precision_given;
    // sign eats one column of a zero-padded field
    eff_w     = (wid != '0 && zpad_eff && has_sign) ? wid - 1'b1 : wid;
    pad_w     = zpad_eff ? eff_w : '0;
    tgt_raw   = (TW'(prec) > TW'(pad_w)) ? TW'(prec) : TW'(pad_w);
    tgt       = (tgt_raw > TW'(CORE_LEN)) ? LEN_W'(CORE_LEN) : LEN_W'(tgt_raw);
    if (in_data_i.left_align) begin
      tgt = '0;
    end
  end

  // ---------------- double-dabble step ----------------
  logic [WORK_W-1:0] adj;
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[4*i +: 4] = (work_q[4*i +: 4] >= 4'd5) ? work_q[4*i +: 4] + 4'd3
                                                 : work_q[4*i +: 4];
    end
  end

  // ---------------- digit extraction ----------------
  logic [3:0]        dig;
  logic [WORK_W-1:0] work_shift;
  logic [7:0]        dig_ch;
  always_comb begin
    dig        = oct_q ? {1'b0, work_q[2:0]} : work_q[3:0];
    work_shift = oct_q ? (work_q >> 3) : (work_q >> 4);
    if (dig < 4'd10) begin
      dig_ch = CH_ZERO + {4'b0, dig};
    end else begin
      dig_ch = (upper_q ? CH_UPPER : CH_LOWER) + {4'b0, dig} - 8'd10;
    end
  end

  // ---------------- stack push/pop ----------------
  logic       sign_ok, push, pop;
  logic [7:0] push_ch;
  assign sign_ok = sign_q && (len_q < LEN_W'(CORE_LEN));
  assign push    = cmd_i.push_digit | cmd_i.push_zero | (cmd_i.push_sign & sign_ok);
  always_comb begin
    if (cmd_i.push_digit) begin
      push_ch = dig_ch;
    end else if (cmd_i.push_zero) begin
      push_ch = CH_ZERO;
    end else begin
      push_ch = sign_ch_q;
    end
  end

  // ---------------- emission ----------------
  logic [SW-1:0] rem;
  logic [TW-1:0] gap;
  logic          wide;
  logic [7:0]    emit_ch;
  assign rem  = SW'(lead_q) + SW'(len_q) + SW'(trail_q);
  assign wide = (TW'(width_q) > TW'(len_q));
  assign gap  = TW'(width_q) - TW'(len_q);
  assign pop  = cmd_i.emit && (lead_q == '0) && (len_q != '0);
  always_comb begin
    if (lead_q != '0) begin
      emit_ch = CH_SPACE;
    end else if (len_q != '0) begin
      emit_ch = core_q[0];
    end else begin
      emit_ch = CH_SPACE;
    end
  end

  // Status to controller
  always_comb begin
    sts_o             = '0;
    sts_o.skip_digits = skip_q;
    sts_o.is_dec      = dec_q;
    sts_o.dabble_last = (cnt_q == CNT_W'(1));
    sts_o.more_digits = (work_shift != '0) &&
                        ((LEN_W + 1)'(len_q) + 1'b1 < (LEN_W + 1)'(CORE_LEN));
    sts_o.need_zero   = (len_q < tgt_q);
    sts_o.rem_zero    = (rem == '0);
    sts_o.last_one    = (rem == SW'(1));
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // Per-number settings and conversion registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dec_q     <= (in_data_i.radix_sel != RADIX_HEX) && (in_data_i.radix_sel != RADIX_OCT);
      oct_q     <= (in_data_i.radix_sel == RADIX_OCT);
      upper_q   <= in_data_i.upper_case;
      left_q    <= in_data_i.left_align;
      lead_sp_q <= ~in_data_i.left_align & ~zpad_eff;
      sign_q    <= has_sign;
      sign_ch_q <= sign_ch;
      skip_q    <= in_data_i.precision_given && (val == '0);
      width_q   <= wid;
      tgt_q     <= tgt;
      bin_q     <= val;
      work_q    <= (in_data_i.radix_sel != RADIX_HEX && in_data_i.radix_sel != RADIX_OCT)
                   ? '0 : WORK_W'(val);
      cnt_q     <= CNT_W'(VALUE_BITS);
    end else if (cmd_i.dabble) begin
      work_q <= {adj[WORK_W-2:0], bin_q[VALUE_BITS-1]};
      bin_q  <= bin_q << 1;
      cnt_q  <= cnt_q - 1'b1;
    end else if (cmd_i.push_digit) begin
      work_q <= work_shift;
    end
  end

  // Character stack
  always_ff @(posedge clk_i) begin
    if (push) begin
      core_q[0] <= push_ch;
      for (int j = 1; j < CORE_LEN; j++) begin
        core_q[j] <= core_q[j-1];
      end
    end else if (pop) begin
      for (int j = 0; j < CORE_LEN - 1; j++) begin
        core_q[j] <= core_q[j+1];
      end
    end
  end

  // Counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      lead_q  <= '0;
      trail_q <= '0;
    end else begin
      if (cmd_i.load) begin
        len_q   <= '0;
        lead_q  <= '0;
        trail_q <= '0;
      end else if (push) begin
        len_q <= len_q + 1'b1;
      end else if (cmd_i.prep) begin
        lead_q  <= (lead_sp_q && wide) ? WID_W'(gap) : '0;
        trail_q <= (left_q && wide) ? WID_W'(gap) : '0;
      end else if (cmd_i.emit) begin
        if (lead_q != '0) begin
          lead_q <= lead_q - 1'b1;
        end else if (len_q != '0) begin
          len_q <= len_q - 1'b1;
        end else begin
          trail_q <= trail_q - 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.character <= emit_ch;
      out_q.last_char <= (rem == SW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level, printf-style integer to ASCII text.
// Instantiates itoa_ctrl and itoa_dp. Depends on itoa_pkg.
//
// Takes one number with its conversion spec per input transaction and emits
// the text one character per output transaction, last_char set on the final
// one. Decimal goes through a binary-to-BCD shifter that consumes one value
// bit per cycle; then the digits are peeled off one per cycle, padding zeros
// are pushed one per cycle, and the characters leave through the output
// register at one per cycle while the output is not stalled. The input
// stalls from acceptance until the final character is loaded into the output
// register; the next number can be taken while that character still waits.
// A number that produces no text gives no output.
module integer_to_ascii_formatter #(
  parameter int unsigned CORE_LEN   = itoa_pkg::CORE_LEN_DEF,
  parameter int unsigned MAX_WIDTH  = itoa_pkg::MAX_WIDTH_DEF,
  parameter int unsigned VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itoa_pkg::itoa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itoa_pkg::itoa_out_t out_data_o
);
  import itoa_pkg::*;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  // Sequencer
  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  itoa_dp #(
    .CORE_LEN   (CORE_LEN),
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/itoa_chk.sv
// itoa_chk: port-level checks for integer_to_ascii_formatter, bound to it.
// Depends on itoa_pkg.
module itoa_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input itoa_pkg::itoa_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input itoa_pkg::itoa_out_t out_data_o
);
  import itoa_pkg::*;

  // A stalled character stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // and does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  // One number at a time: input closes right after a transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A new number never starts while a non-final character is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !(out_valid_o && !out_data_o.last_char))
    else $error("new number accepted mid-text");

endmodule

bind integer_to_ascii_formatter itoa_chk u_itoa_chk (.*);
